// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
// Each macro takes a label, the clock, the active-low reset and two expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication
`define ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== sv/sls_pkg.sv =====
// ----------------------------------------------------------------------------
// sls_pkg
// Types, token codes and keyword table of the script lexer token scanner.
// ----------------------------------------------------------------------------
package sls_pkg;

  // Sizes
  localparam int POSITION_BITS   = 16;
  localparam int LINE_BITS       = 16;
  localparam int KEYWORD_MAX_LEN = 5;
  localparam int WIN_W           = 8 * KEYWORD_MAX_LEN;
  localparam int MAX_RES         = 3;
  localparam int FIFO_DEPTH      = 4;
  localparam int FIFO_AW         = $clog2(FIFO_DEPTH);
  localparam int NUM_KW          = 14;

  typedef logic [POSITION_BITS-1:0]     pos_t;
  typedef logic [POSITION_BITS:0]       pos1_t;
  typedef logic [LINE_BITS-1:0]         line_t;
  typedef logic [WIN_W-1:0]             win_t;
  typedef logic [5:0]                   kind_t;
  typedef logic [1:0]                   err_t;
  typedef logic [$clog2(MAX_RES+1)-1:0] rcnt_t;
  typedef logic [FIFO_AW-1:0]           fptr_t;
  typedef logic [FIFO_AW:0]             fcnt_t;

  // Scan modes
  typedef enum logic [3:0] {
    M_IDLE    = 4'd0,
    M_IDENT   = 4'd1,
    M_NUM     = 4'd2,
    M_NUMDOT  = 4'd3,
    M_FRAC    = 4'd4,
    M_STR     = 4'd5,
    M_COMMENT = 4'd6,
    M_BANG    = 4'd7,
    M_EQ      = 4'd8,
    M_LESS    = 4'd9,
    M_GREATER = 4'd10
  } mode_t;

  // Token kinds
  localparam kind_t K_DOT     = 6'd8;
  localparam kind_t K_BANG    = 6'd15;
  localparam kind_t K_ASSIGN  = 6'd17;
  localparam kind_t K_LESS    = 6'd19;
  localparam kind_t K_GREATER = 6'd21;
  localparam kind_t K_IDENT   = 6'd23;
  localparam kind_t K_STRING  = 6'd24;
  localparam kind_t K_NUMBER  = 6'd25;
  localparam kind_t K_KW_BASE = 6'd26;
  localparam kind_t K_ERROR   = 6'd40;
  localparam kind_t K_EOF     = 6'd41;

  // Error codes
  localparam err_t E_NONE     = 2'd0;
  localparam err_t E_UNEXP    = 2'd1;
  localparam err_t E_UNTERM   = 2'd2;

  // One result
  typedef struct packed {
    kind_t       kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [15:0] line;
    err_t        err;
    logic        last;
  } tok_t;

  // All results caused by one request
  typedef struct packed {
    tok_t [MAX_RES-1:0] toks;
    rcnt_t              cnt;
  } res_t;

  // Keyword text, first byte in the low bits; kind is K_KW_BASE plus the index
  localparam logic [63:0] KW_TEXT [NUM_KW] = '{
    64'h0000_0000_0064_6E61, // and
    64'h0000_0000_6573_6162, // base
    64'h0000_0000_6573_6C65, // else
    64'h0000_0065_736C_6166, // false
    64'h0000_0000_0072_6F66, // for
    64'h0000_0000_636E_7566, // func
    64'h0000_0000_0000_6669, // if
    64'h0000_0000_6C6C_756E, // null
    64'h0000_0000_0000_726F, // or
    64'h0000_0074_6E69_7270, // print
    64'h0000_0000_0067_6572, // reg
    64'h0000_0000_666C_6573, // self
    64'h0000_0000_6575_7274, // true
    64'h0000_0000_0072_6176  // var
  };
  localparam int KW_LEN [NUM_KW] = '{3, 4, 4, 5, 3, 4, 2, 4, 2, 5, 3, 4, 4, 3};

  // Clamp a position-sized value to the 16-bit token field
  function automatic logic [15:0] sat_pos16(pos1_t v);
    logic [POSITION_BITS+16:0] w;
    w = {16'b0, v};
    return (w > 'hFFFF) ? 16'hFFFF : w[15:0];
  endfunction

  // Clamp a line count to the 16-bit token field
  function automatic logic [15:0] sat_line16(line_t v);
    logic [LINE_BITS+15:0] w;
    w = {16'b0, v};
    return (w > 'hFFFF) ? 16'hFFFF : w[15:0];
  endfunction

endpackage

// ===== sv/sls_core.sv =====
// ----------------------------------------------------------------------------
// sls_core
// Scan state registers and the single-pass token decision for one byte.
// ----------------------------------------------------------------------------
module sls_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          take,
  input  logic [7:0]    code_byte,
  output sls_pkg::res_t res
);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;

  localparam sls_pkg::pos_t  POS_MAX  = '1;
  localparam sls_pkg::line_t LINE_MAX = '1;

  sls_pkg::mode_t mode_r, mode_nxt;
  sls_pkg::pos_t  pos_r, pos_nxt;
  sls_pkg::pos_t  ls_r, ls_nxt;
  sls_pkg::line_t line_r, line_nxt;
  sls_pkg::win_t  win_r, win_nxt;

  sls_pkg::pos_t  pos_adv;
  sls_pkg::line_t line_adv;
  sls_pkg::pos_t  idx;
  sls_pkg::pos_t  dot;
  sls_pkg::kind_t op_base;
  sls_pkg::kind_t id_kind;
  sls_pkg::res_t  res_c;
  sls_pkg::rcnt_t n;
  logic           do_idle;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  // Single-byte punctuation; anything else is unexpected
  function automatic sls_pkg::kind_t single_kind(logic [7:0] c);
    sls_pkg::kind_t k;
    unique case (c)
      8'h28:   k = 6'd0;
      8'h29:   k = 6'd1;
      8'h7B:   k = 6'd2;
      8'h7D:   k = 6'd3;
      8'h5B:   k = 6'd4;
      8'h5D:   k = 6'd5;
      8'h3B:   k = 6'd6;
      8'h2C:   k = 6'd7;
      8'h2E:   k = 6'd8;
      8'h2D:   k = 6'd9;
      8'h2B:   k = 6'd10;
      8'h2F:   k = 6'd11;
      8'h2A:   k = 6'd12;
      8'h5E:   k = 6'd13;
      8'h25:   k = 6'd14;
      default: k = sls_pkg::K_ERROR;
    endcase
    return k;
  endfunction

  // Build one result from a start and an end offset
  function automatic sls_pkg::tok_t mk_tok(sls_pkg::kind_t kind, sls_pkg::pos1_t st,
                                           sls_pkg::pos1_t fin, sls_pkg::line_t ln,
                                           sls_pkg::err_t err);
    sls_pkg::tok_t t;
    sls_pkg::pos1_t len;
    len      = (fin >= st) ? fin - st : '0;
    t.kind   = kind;
    t.start  = sls_pkg::sat_pos16(st);
    t.length = sls_pkg::sat_pos16(len);
    t.line   = sls_pkg::sat_line16(ln);
    t.err    = err;
    t.last   = 1'b0;
    return t;
  endfunction

  // Exact keyword match on the first len identifier bytes held
  function automatic sls_pkg::kind_t kw_kind(sls_pkg::win_t win, sls_pkg::pos_t len);
    sls_pkg::kind_t k;
    logic [63:0]    txt;
    logic [63:0]    mask;
    k = sls_pkg::K_IDENT;
    if (len != '0 && len <= sls_pkg::pos_t'(sls_pkg::KEYWORD_MAX_LEN)) begin
      for (int i = 0; i < sls_pkg::NUM_KW; i++) begin
        txt  = sls_pkg::KW_TEXT[i];
        mask = (64'd1 << (8 * sls_pkg::KW_LEN[i])) - 64'd1;
        if (len == sls_pkg::pos_t'(sls_pkg::KW_LEN[i]) &&
            (win & mask[sls_pkg::WIN_W-1:0]) == txt[sls_pkg::WIN_W-1:0]) begin
          k = sls_pkg::K_KW_BASE + sls_pkg::kind_t'(i);
        end
      end
    end
    return k;
  endfunction

  // Saturating increments
  assign pos_adv  = (pos_r != POS_MAX) ? pos_r + 1'b1 : pos_r;
  assign line_adv = (line_r != LINE_MAX) ? line_r + 1'b1 : line_r;
  assign idx      = pos_r - ls_r;
  assign dot      = (pos_r > ls_r) ? pos_r - 1'b1 : ls_r;
  assign id_kind  = kw_kind(win_r, (pos_r >= ls_r) ? idx : '0);

  // Operator base kind for the pending one-byte operator
  always_comb begin
    unique case (mode_r)
      sls_pkg::M_BANG:    op_base = sls_pkg::K_BANG;
      sls_pkg::M_EQ:      op_base = sls_pkg::K_ASSIGN;
      sls_pkg::M_LESS:    op_base = sls_pkg::K_LESS;
      default:            op_base = sls_pkg::K_GREATER;
    endcase
  end

  // Decide the next state and the results for this byte
  always_comb begin
    mode_nxt = mode_r;
    pos_nxt  = pos_r;
    ls_nxt   = ls_r;
    line_nxt = line_r;
    win_nxt  = win_r;
    res_c    = '0;
    n        = '0;
    do_idle  = 1'b0;

    // Pending lexeme: grow it or flush it
    unique case (mode_r)
      sls_pkg::M_IDENT: begin
        if (is_alpha(code_byte) || is_digit(code_byte)) begin
          if (pos_r >= ls_r) begin
            for (int j = 0; j < sls_pkg::KEYWORD_MAX_LEN; j++) begin
              if (idx == sls_pkg::pos_t'(j)) begin
                win_nxt[8*j +: 8] = win_r[8*j +: 8] | code_byte;
              end
            end
          end
          pos_nxt = pos_adv;
        end else begin
          res_c.toks[n] = mk_tok(id_kind, {1'b0, ls_r}, {1'b0, pos_r}, line_r,
                                 sls_pkg::E_NONE);
          n = n + 1'b1;
          do_idle = 1'b1;
        end
      end
      sls_pkg::M_NUM: begin
        if (is_digit(code_byte)) begin
          pos_nxt = pos_adv;
        end else if (code_byte == CH_DOT) begin
          mode_nxt = sls_pkg::M_NUMDOT;
          pos_nxt  = pos_adv;
        end else begin
          res_c.toks[n] = mk_tok(sls_pkg::K_NUMBER, {1'b0, ls_r}, {1'b0, pos_r}, line_r,
                                 sls_pkg::E_NONE);
          n = n + 1'b1;
          do_idle = 1'b1;
        end
      end
      sls_pkg::M_NUMDOT: begin
        if (is_digit(code_byte)) begin
          mode_nxt = sls_pkg::M_FRAC;
          pos_nxt  = pos_adv;
        end else begin
          // Split into the number and a trailing dot
          res_c.toks[n] = mk_tok(sls_pkg::K_NUMBER, {1'b0, ls_r}, {1'b0, dot}, line_r,
                                 sls_pkg::E_NONE);
          n = n + 1'b1;
          res_c.toks[n] = mk_tok(sls_pkg::K_DOT, {1'b0, dot}, {1'b0, dot} + 1'b1, line_r,
                                 sls_pkg::E_NONE);
          n = n + 1'b1;
          do_idle = 1'b1;
        end
      end
      sls_pkg::M_FRAC: begin
        if (is_digit(code_byte)) begin
          pos_nxt = pos_adv;
        end else begin
          res_c.toks[n] = mk_tok(sls_pkg::K_NUMBER, {1'b0, ls_r}, {1'b0, pos_r}, line_r,
                                 sls_pkg::E_NONE);
          n = n + 1'b1;
          do_idle = 1'b1;
        end
      end
      sls_pkg::M_STR: begin
        if (code_byte == CH_NUL) begin
          res_c.toks[n] = mk_tok(sls_pkg::K_ERROR, {1'b0, ls_r}, {1'b0, pos_r}, line_r,
                                 sls_pkg::E_UNTERM);
          n = n + 1'b1;
          do_idle = 1'b1;
        end else if (code_byte == CH_QUOTE) begin
          res_c.toks[n] = mk_tok(sls_pkg::K_STRING, {1'b0, ls_r}, {1'b0, pos_r} + 1'b1,
                                 line_r, sls_pkg::E_NONE);
          n = n + 1'b1;
          mode_nxt = sls_pkg::M_IDLE;
          pos_nxt  = pos_adv;
        end else begin
          if (code_byte == CH_NL) begin
            line_nxt = line_adv;
          end
          pos_nxt = pos_adv;
        end
      end
      sls_pkg::M_COMMENT: begin
        if (code_byte != CH_NUL && code_byte != CH_NL) begin
          pos_nxt = pos_adv;
        end else begin
          do_idle = 1'b1;
        end
      end
      sls_pkg::M_BANG, sls_pkg::M_EQ, sls_pkg::M_LESS, sls_pkg::M_GREATER: begin
        if (code_byte == CH_EQ) begin
          res_c.toks[n] = mk_tok(op_base + 1'b1, {1'b0, ls_r}, {1'b0, pos_r} + 1'b1,
                                 line_r, sls_pkg::E_NONE);
          n = n + 1'b1;
          mode_nxt = sls_pkg::M_IDLE;
          pos_nxt  = pos_adv;
        end else begin
          res_c.toks[n] = mk_tok(op_base, {1'b0, ls_r}, {1'b0, pos_r}, line_r,
                                 sls_pkg::E_NONE);
          n = n + 1'b1;
          do_idle = 1'b1;
        end
      end
      default: begin
        do_idle = 1'b1;
      end
    endcase

    // Start-of-lexeme handling of the byte
    if (do_idle) begin
      mode_nxt = sls_pkg::M_IDLE;
      priority if (code_byte == CH_NUL) begin
        res_c.toks[n] = mk_tok(sls_pkg::K_EOF, {1'b0, pos_r}, {1'b0, pos_r}, line_r,
                               sls_pkg::E_NONE);
        n = n + 1'b1;
        pos_nxt  = '0;
        ls_nxt   = '0;
        line_nxt = sls_pkg::line_t'(1);
        win_nxt  = '0;
      end else if (code_byte == CH_SP || code_byte == CH_CR || code_byte == CH_TAB) begin
        pos_nxt = pos_adv;
      end else if (code_byte == CH_NL) begin
        line_nxt = line_adv;
        pos_nxt  = pos_adv;
      end else if (code_byte == CH_HASH) begin
        mode_nxt = sls_pkg::M_COMMENT;
        pos_nxt  = pos_adv;
      end else if (is_alpha(code_byte)) begin
        mode_nxt = sls_pkg::M_IDENT;
        ls_nxt   = pos_r;
        win_nxt  = sls_pkg::win_t'(code_byte);
        pos_nxt  = pos_adv;
      end else if (is_digit(code_byte)) begin
        mode_nxt = sls_pkg::M_NUM;
        ls_nxt   = pos_r;
        pos_nxt  = pos_adv;
      end else if (code_byte == CH_QUOTE) begin
        mode_nxt = sls_pkg::M_STR;
        ls_nxt   = pos_r;
        pos_nxt  = pos_adv;
      end else if (code_byte == CH_BANG) begin
        mode_nxt = sls_pkg::M_BANG;
        ls_nxt   = pos_r;
        pos_nxt  = pos_adv;
      end else if (code_byte == CH_EQ) begin
        mode_nxt = sls_pkg::M_EQ;
        ls_nxt   = pos_r;
        pos_nxt  = pos_adv;
      end else if (code_byte == CH_LT) begin
        mode_nxt = sls_pkg::M_LESS;
        ls_nxt   = pos_r;
        pos_nxt  = pos_adv;
      end else if (code_byte == CH_GT) begin
        mode_nxt = sls_pkg::M_GREATER;
        ls_nxt   = pos_r;
        pos_nxt  = pos_adv;
      end else begin
        res_c.toks[n] = mk_tok(single_kind(code_byte), {1'b0, pos_r}, {1'b0, pos_r} + 1'b1,
                               line_r, (single_kind(code_byte) == sls_pkg::K_ERROR) ?
                               sls_pkg::E_UNEXP : sls_pkg::E_NONE);
        n = n + 1'b1;
        ls_nxt  = pos_r;
        pos_nxt = pos_adv;
      end
    end

    // Mark the final result of this request
    if (n != '0) begin
      res_c.toks[n - 1'b1].last = 1'b1;
    end
    res_c.cnt = n;
  end

  assign res = res_c;

  // Scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= sls_pkg::M_IDLE;
      pos_r  <= '0;
      ls_r   <= '0;
      line_r <= sls_pkg::line_t'(1);
      win_r  <= '0;
    end else if (take) begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
      ls_r   <= ls_nxt;
      line_r <= line_nxt;
      win_r  <= win_nxt;
    end
  end

endmodule

// ===== sv/sls_fifo.sv =====
// ----------------------------------------------------------------------------
// sls_fifo
// Result queue: takes a request's results at once, hands out one a cycle on pop.
// ----------------------------------------------------------------------------
module sls_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sls_pkg::res_t res,
  input  logic          pop,
  output logic          room,
  output logic          head_valid,
  output sls_pkg::tok_t head
);

  sls_pkg::tok_t  mem [sls_pkg::FIFO_DEPTH];
  sls_pkg::fptr_t wr_ptr_r, wr_ptr_nxt;
  sls_pkg::fptr_t rd_ptr_r, rd_ptr_nxt;
  sls_pkg::fcnt_t cnt_r, cnt_nxt;
  sls_pkg::fcnt_t push_cnt;

  assign push_cnt   = push ? sls_pkg::fcnt_t'(res.cnt) : '0;
  assign wr_ptr_nxt = wr_ptr_r + sls_pkg::fptr_t'(push_cnt);
  assign rd_ptr_nxt = rd_ptr_r + sls_pkg::fptr_t'(pop);
  assign cnt_nxt    = cnt_r + push_cnt - sls_pkg::fcnt_t'(pop);

  // Room for a full burst of results
  assign room       = cnt_r <= sls_pkg::fcnt_t'(sls_pkg::FIFO_DEPTH - sls_pkg::MAX_RES);
  assign head_valid = cnt_r != '0;
  assign head       = mem[rd_ptr_r];

  // Store the burst in consecutive entries
  always_ff @(posedge clk) begin
    if (push) begin
      for (int k = 0; k < sls_pkg::MAX_RES; k++) begin
        if (sls_pkg::rcnt_t'(k) < res.cnt) begin
          mem[wr_ptr_r + sls_pkg::fptr_t'(k)] <= res.toks[k];
        end
      end
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== sv/script_lexer_token_scanner.sv =====
// ----------------------------------------------------------------------------
// script_lexer_token_scanner
// Streaming lexical scanner: source bytes in, tokens out.
// ----------------------------------------------------------------------------
// One source byte is taken per request and decided in the same cycle; the
// zero to three tokens it completes enter a four-entry result queue and
// leave it one per cycle from the next cycle on while out_stall is low.
// Input is held off while fewer than three queue entries are free, so with
// the output side taking every cycle the scanner sustains one byte per
// cycle; a byte that yields two or three tokens (number then dot,
// unterminated string then end of text) holds the input off while the
// queue drains. Byte 0 ends the text: an end-of-text token follows and
// position and line start over. No start-up pass is needed after reset.
module script_lexer_token_scanner (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_code_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_token_kind,
  output logic [15:0] out_token_start,
  output logic [15:0] out_token_length,
  output logic [15:0] out_token_line,
  output logic [1:0]  out_error_code,
  output logic        out_last_of_run
);

  logic          take;
  logic          room;
  logic          pop;
  sls_pkg::res_t res;
  sls_pkg::tok_t head;

  // Accept a request only with room for its whole burst
  assign in_stall = !room;
  assign take     = in_valid && room;
  assign pop      = out_valid && !out_stall;

  sls_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .code_byte (in_code_byte),
    .res       (res)
  );

  sls_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (take),
    .res        (res),
    .pop        (pop),
    .room       (room),
    .head_valid (out_valid),
    .head       (head)
  );

  // Drive the result ports from the queue head
  assign out_token_kind   = head.kind;
  assign out_token_start  = head.start;
  assign out_token_length = head.length;
  assign out_token_line   = head.line;
  assign out_error_code   = head.err;
  assign out_last_of_run  = head.last;

endmodule

// ===== sv/sls_checker.sv =====
// ----------------------------------------------------------------------------
// sls_checker
// Port-level checks of the script lexer token scanner, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sls_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_code_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [5:0]  out_token_kind,
  input logic [15:0] out_token_start,
  input logic [15:0] out_token_length,
  input logic [15:0] out_token_line,
  input logic [1:0]  out_error_code,
  input logic        out_last_of_run
);

  logic in_hold;
  logic out_hold;
  logic err_set;
  logic eof_seen;
  logic mid_burst_pop;

  assign in_hold       = in_valid && in_stall;
  assign out_hold      = out_valid && out_stall;
  assign err_set       = out_valid && (out_error_code != sls_pkg::E_NONE);
  assign eof_seen      = out_valid && (out_token_kind == sls_pkg::K_EOF);
  assign mid_burst_pop = out_valid && !out_stall && !out_last_of_run;

  // A stalled request holds
  `ASSERT_NXT(a_in_hold, clk, rst_n, in_hold, in_valid && $stable(in_code_byte))
  // A stalled result holds
  `ASSERT_NXT(a_out_hold, clk, rst_n, out_hold, out_valid && $stable(out_token_kind) && $stable(out_token_start) && $stable(out_token_length) && $stable(out_token_line) && $stable(out_error_code) && $stable(out_last_of_run))
  // Only error tokens carry an error code
  `ASSERT_IMP(a_err_kind, clk, rst_n, err_set, out_token_kind == sls_pkg::K_ERROR)
  // End of text is empty, error-free and closes its burst
  `ASSERT_IMP(a_eof_shape, clk, rst_n, eof_seen, out_token_length == 16'd0 && out_error_code == sls_pkg::E_NONE && out_last_of_run)
  // The rest of a burst is already queued
  `ASSERT_NXT(a_burst_cont, clk, rst_n, mid_burst_pop, out_valid)

endmodule

bind script_lexer_token_scanner sls_checker u_sls_checker (.*);
